@@ design/mpi_pkg.sv @@
// ----------------------------------------------------------------------------
// mpi_pkg
// Shared constants, codes and command/status types of the pseudo-inverse core.
// ----------------------------------------------------------------------------
`default_nettype none

package mpi_pkg;

  localparam int unsigned MAX_ROWS      = 8;
  localparam int unsigned MAX_COLS      = 8;
  localparam int unsigned AUG_W         = 2 * MAX_COLS;
  localparam int unsigned IN_DEPTH      = MAX_ROWS * MAX_COLS;
  localparam int unsigned AUG_DEPTH     = MAX_COLS * AUG_W;
  localparam int unsigned RES_DEPTH     = MAX_ROWS * MAX_COLS;
  localparam int unsigned IN_AW         = $clog2(IN_DEPTH);
  localparam int unsigned AUG_AW        = $clog2(AUG_DEPTH);
  localparam int unsigned RES_AW        = $clog2(RES_DEPTH);
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned JW            = 5;
  localparam int unsigned CNT_W         = 7;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned CFG_AW        = 3;
  localparam int unsigned DEF_FRAC_BITS = 16;

  localparam logic       REG_ROW_COUNT = 1'b0;
  localparam logic       REG_COL_COUNT = 1'b1;
  localparam logic [3:0] COUNT_RESET   = 4'd6;

  typedef enum logic [2:0] {
    W_ACC,
    W_ONE,
    W_ZERO,
    W_PORT_A,
    W_PORT_B,
    W_QUOT,
    W_DIFF
  } aug_wsel_e;

  typedef enum logic [1:0] {
    MUL_GRAM,
    MUL_ELIM,
    MUL_OUT
  } mul_sel_e;

  typedef struct packed {
    logic              in_we;
    logic [IN_AW-1:0]  in_waddr;
    logic [IN_AW-1:0]  in_raddr_a;
    logic [IN_AW-1:0]  in_raddr_b;
    logic              aug_we;
    logic [AUG_AW-1:0] aug_waddr;
    aug_wsel_e         aug_wsel;
    logic [AUG_AW-1:0] aug_raddr_a;
    logic [AUG_AW-1:0] aug_raddr_b;
    logic              res_we;
    logic [RES_AW-1:0] res_addr;
    logic              mul_en;
    mul_sel_e          mul_sel;
    logic              acc_clr;
    logic              acc_en;
    logic              best_ld;
    logic              best_first;
    logic              d_ld;
    logic              f_ld;
    logic              div_start;
    logic              sat_clr;
  } dp_cmd_t;

  typedef struct packed {
    logic a_zero;
    logic mag_gt;
    logic div_busy;
  } dp_status_t;

endpackage

`default_nettype wire

@@ design/mpi_if.sv @@
// ----------------------------------------------------------------------------
// mpi_elem_if / mpi_result_if
// Valid/ready channels for matrix elements in and pseudo-inverse words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpi_elem_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] element_value;
  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

interface mpi_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [2:0]         result_row;
  logic [2:0]         result_col;
  logic               last_of_run;
  logic               saturated;
  modport source (output valid, output result_value, output result_row, output result_col,
                  output last_of_run, output saturated, input ready);
  modport sink   (input valid, input result_value, input result_row, input result_col,
                  input last_of_run, input saturated, output ready);
endinterface

`default_nettype wire

@@ design/matrix_pseudo_inverse_core.sv @@
// ----------------------------------------------------------------------------
// matrix_pseudo_inverse_core
// Moore-Penrose pseudo-inverse of an R x C fixed-point matrix.
// ----------------------------------------------------------------------------
// Usage: program row_count and col_count over the APB port (byte addresses
// 0 and 4), then stream the R*C elements of M in row-major order on elem_in,
// one word per accepted handshake. After the last word the core stops
// accepting input and computes MtM, its Gauss-Jordan inverse and the product
// with Mt, then sends the C x R result on res_out while the receiver is ready,
// each word read from the result memory before it is offered, with
// last_of_run on the final word and the run's saturation flag on every word.
// The Gram and output products run on the shared multiplier, and at full size
// normalization dominates the compute, since every pivot-row word goes
// through the serial divider at one quotient bit per cycle.
// A stalled receiver simply holds the current word; nothing is lost.
// Reset returns the counts to 6, clears the load count and the flag; the
// memories are not cleared. Writing a count restarts the load.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_pseudo_inverse_core #(
  parameter int unsigned FRAC_BITS = mpi_pkg::DEF_FRAC_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  mpi_elem_if.sink                         elem_in,
  mpi_result_if.source                     res_out,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mpi_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  logic [3:0]          row_count_q, col_count_q;
  logic [3:0]          nr, nc;
  logic                cfg_wr;
  mpi_pkg::dp_cmd_t    cmd;
  mpi_pkg::dp_status_t status;

  // Counts of zero act as one; counts above the maximum are clamped.
  function automatic logic [3:0] clamp_count(input logic [3:0] v, input logic [3:0] mx);
    logic [3:0] r;
    r = v;
    if (r == 4'd0) r = 4'd1;
    if (r > mx) r = mx;
    return r;
  endfunction

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= mpi_pkg::COUNT_RESET;
      col_count_q <= mpi_pkg::COUNT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == mpi_pkg::REG_ROW_COUNT) row_count_q <= pwdata[3:0];
      else                                     col_count_q <= pwdata[3:0];
    end
  end

  assign prdata = {28'b0, (paddr[2] == mpi_pkg::REG_COL_COUNT) ? col_count_q : row_count_q};

  assign nr = clamp_count(row_count_q, 4'(mpi_pkg::MAX_ROWS));
  assign nc = clamp_count(col_count_q, 4'(mpi_pkg::MAX_COLS));

  mpi_controller u_ctrl (
    .clk_i,
    .rst_ni,
    .nr_i        (nr),
    .nc_i        (nc),
    .cfg_wr_i    (cfg_wr),
    .in_valid_i  (elem_in.valid),
    .in_ready_o  (elem_in.ready),
    .out_ready_i (res_out.ready),
    .out_valid_o (res_out.valid),
    .out_row_o   (res_out.result_row),
    .out_col_o   (res_out.result_col),
    .out_last_o  (res_out.last_of_run),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mpi_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .elem_i      (elem_in.element_value),
    .status_o    (status),
    .res_value_o (res_out.result_value),
    .sat_o       (res_out.saturated)
  );

  // The core never takes input while a result word is on offer.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out.valid |-> !elem_in.ready)
    else $error("input accepted during result delivery");

  // Taking the final word of a run returns the core to loading.
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_out.valid && res_out.ready && res_out.last_of_run) |=> elem_in.ready)
    else $error("core did not return to loading after the last word");

endmodule

`default_nettype wire

@@ design/mpi_ram.sv @@
// ----------------------------------------------------------------------------
// mpi_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mpi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                     wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]                     rdata_a_o,
  output logic      [WIDTH-1:0]                     rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

@@ design/mpi_divider.sv @@
// ----------------------------------------------------------------------------
// mpi_divider
// Restoring divider for pivot normalization: (x * 2^FRAC_BITS) / d, one
// quotient bit per cycle, truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mpi_divider #(
  parameter int unsigned FRAC_BITS = mpi_pkg::DEF_FRAC_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] num_i,
  input  wire logic signed [31:0] den_i,
  output logic                    busy_o,
  output logic signed [31:0]      quot_o,
  output logic                    ovf_o
);

  localparam int unsigned NW = 32 + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] n_q;
  logic [31:0]   rem_q;
  logic [31:0]   dmag_q;
  logic          neg_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;

  logic [31:0] nmag, dmag;
  logic [32:0] trial;
  logic        take;

  assign nmag  = num_i[31] ? (~num_i + 32'd1) : num_i;
  assign dmag  = den_i[31] ? (~den_i + 32'd1) : den_i;
  assign trial = {rem_q, n_q[NW-1]};
  assign take  = (trial >= {1'b0, dmag_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= {nmag, {FRAC_BITS{1'b0}}};
      rem_q  <= '0;
      dmag_q <= dmag;
      neg_q  <= num_i[31] ^ den_i[31];
    end else if (busy_q) begin
      rem_q <= take ? 32'(trial - {1'b0, dmag_q}) : trial[31:0];
      n_q   <= {n_q[NW-2:0], take};
    end
  end

  always_comb begin
    ovf_o  = 1'b0;
    quot_o = signed'(n_q[31:0]);
    if (neg_q) begin
      if ((|n_q[NW-1:32]) || (n_q[31] && (|n_q[30:0]))) begin
        ovf_o  = 1'b1;
        quot_o = 32'sh8000_0000;
      end else begin
        quot_o = signed'(~n_q[31:0] + 32'd1);
      end
    end else if (|n_q[NW-1:31]) begin
      ovf_o  = 1'b1;
      quot_o = 32'sh7fff_ffff;
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

@@ design/mpi_datapath.sv @@
// ----------------------------------------------------------------------------
// mpi_datapath
// Element, elimination and result memories, the multiply/accumulate path,
// pivot compare, divider and the sticky saturation flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mpi_datapath #(
  parameter int unsigned FRAC_BITS = mpi_pkg::DEF_FRAC_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mpi_pkg::dp_cmd_t    cmd_i,
  input  wire logic signed [31:0]  elem_i,
  output mpi_pkg::dp_status_t      status_o,
  output logic signed [31:0]       res_value_o,
  output logic                     sat_o
);

  localparam int unsigned PW = 2 * mpi_pkg::DATA_W;
  localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] S_MAX  = 32'sh7fff_ffff;
  localparam logic signed [31:0] S_MIN  = 32'sh8000_0000;

  logic signed [31:0] in_rd_a, in_rd_b, aug_rd_a, aug_rd_b, res_rd, res_rd_b;
  logic signed [31:0] aug_wdata;
  logic signed [31:0] acc_q, f_q, d_q;
  logic        [31:0] best_q, mag_a;
  logic signed [PW-1:0] prod_q, prod_shr;
  logic signed [31:0] mul_a, mul_b, mul_val;
  logic               mul_ovf;
  logic signed [32:0] sum, diff;
  logic signed [31:0] sum_val, diff_val;
  logic               sum_ovf, diff_ovf;
  logic signed [31:0] quot;
  logic               div_ovf, div_busy;
  logic               sat_q, sat_set;

  mpi_ram #(.WIDTH(32), .DEPTH(mpi_pkg::IN_DEPTH)) u_in_ram (
    .clk_i, .we_i(cmd_i.in_we), .waddr_i(cmd_i.in_waddr), .wdata_i(elem_i),
    .raddr_a_i(cmd_i.in_raddr_a), .raddr_b_i(cmd_i.in_raddr_b),
    .rdata_a_o(in_rd_a), .rdata_b_o(in_rd_b)
  );

  mpi_ram #(.WIDTH(32), .DEPTH(mpi_pkg::AUG_DEPTH)) u_aug_ram (
    .clk_i, .we_i(cmd_i.aug_we), .waddr_i(cmd_i.aug_waddr), .wdata_i(aug_wdata),
    .raddr_a_i(cmd_i.aug_raddr_a), .raddr_b_i(cmd_i.aug_raddr_b),
    .rdata_a_o(aug_rd_a), .rdata_b_o(aug_rd_b)
  );

  mpi_ram #(.WIDTH(32), .DEPTH(mpi_pkg::RES_DEPTH)) u_res_ram (
    .clk_i, .we_i(cmd_i.res_we), .waddr_i(cmd_i.res_addr), .wdata_i(acc_q),
    .raddr_a_i(cmd_i.res_addr), .raddr_b_i(cmd_i.res_addr),
    .rdata_a_o(res_rd), .rdata_b_o(res_rd_b)
  );

  mpi_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(aug_rd_a), .den_i(d_q),
    .busy_o(div_busy), .quot_o(quot), .ovf_o(div_ovf)
  );

  always_comb begin
    case (cmd_i.mul_sel)
      mpi_pkg::MUL_GRAM: begin mul_a = in_rd_a;  mul_b = in_rd_b;  end
      mpi_pkg::MUL_ELIM: begin mul_a = f_q;      mul_b = aug_rd_b; end
      mpi_pkg::MUL_OUT:  begin mul_a = aug_rd_a; mul_b = in_rd_a;  end
      default:           begin mul_a = in_rd_a;  mul_b = in_rd_b;  end
    endcase
  end

  // Arithmetic shift of the exact product rounds toward minus infinity.
  assign prod_shr = prod_q >>> FRAC_BITS;
  assign mul_ovf  = (prod_shr[PW-1:31] != {(PW-31){prod_shr[PW-1]}});
  assign mul_val  = mul_ovf ? (prod_shr[PW-1] ? S_MIN : S_MAX) : prod_shr[31:0];

  assign sum      = {acc_q[31], acc_q} + {mul_val[31], mul_val};
  assign sum_ovf  = (sum[32] != sum[31]);
  assign sum_val  = sum_ovf ? (sum[32] ? S_MIN : S_MAX) : sum[31:0];
  assign diff     = {aug_rd_a[31], aug_rd_a} - {mul_val[31], mul_val};
  assign diff_ovf = (diff[32] != diff[31]);
  assign diff_val = diff_ovf ? (diff[32] ? S_MIN : S_MAX) : diff[31:0];

  assign mag_a = aug_rd_a[31] ? (~aug_rd_a + 32'd1) : aug_rd_a;

  always_comb begin
    case (cmd_i.aug_wsel)
      mpi_pkg::W_ACC:    aug_wdata = acc_q;
      mpi_pkg::W_ONE:    aug_wdata = ONE_FX;
      mpi_pkg::W_ZERO:   aug_wdata = '0;
      mpi_pkg::W_PORT_A: aug_wdata = aug_rd_a;
      mpi_pkg::W_PORT_B: aug_wdata = aug_rd_b;
      mpi_pkg::W_QUOT:   aug_wdata = quot;
      mpi_pkg::W_DIFF:   aug_wdata = diff_val;
      default:           aug_wdata = '0;
    endcase
  end

  assign sat_set = (cmd_i.acc_en && (mul_ovf || sum_ovf))
                || (cmd_i.aug_we && (cmd_i.aug_wsel == mpi_pkg::W_DIFF) && (mul_ovf || diff_ovf))
                || (cmd_i.aug_we && (cmd_i.aug_wsel == mpi_pkg::W_QUOT) && div_ovf);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en)  prod_q <= mul_a * mul_b;
    if (cmd_i.acc_clr) acc_q  <= '0;
    else if (cmd_i.acc_en) acc_q <= sum_val;
    if (cmd_i.d_ld)    d_q    <= aug_rd_a;
    if (cmd_i.f_ld)    f_q    <= aug_rd_a;
    if (cmd_i.best_ld && (cmd_i.best_first || status_o.mag_gt)) best_q <= mag_a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else if (cmd_i.sat_clr) begin
      sat_q <= 1'b0;
    end else if (sat_set) begin
      sat_q <= 1'b1;
    end
  end

  assign status_o.a_zero   = (aug_rd_a == '0);
  assign status_o.mag_gt   = (mag_a > best_q);
  assign status_o.div_busy = div_busy;
  assign res_value_o       = res_rd;
  assign sat_o             = sat_q;

endmodule

`default_nettype wire

@@ design/mpi_controller.sv @@
// ----------------------------------------------------------------------------
// mpi_controller
// Sequencer: load counting, Gram product, pivoted Gauss-Jordan elimination,
// output product and result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module mpi_controller (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [3:0]                  nr_i,
  input  wire logic [3:0]                  nc_i,
  input  wire logic                        cfg_wr_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic [2:0]                       out_row_o,
  output logic [2:0]                       out_col_o,
  output logic                             out_last_o,
  input  wire mpi_pkg::dp_status_t         status_i,
  output mpi_pkg::dp_cmd_t                 cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_G_RD, S_G_MUL, S_G_ACC, S_G_W1, S_G_W2,
    S_P_RD, S_P_CMP, S_SW_RD, S_SW_W1, S_SW_W2, S_D_RD, S_D_CHK,
    S_N_RD, S_N_GO, S_N_WAIT, S_N_WR, S_F_RD, S_F_LD, S_E_RD, S_E_MUL, S_E_WR,
    S_O_RD, S_O_MUL, S_O_ACC, S_O_WR, S_X_RD, S_X_SHOW
  } state_e;

  state_e                      state_q, state_d;
  logic [mpi_pkg::IDX_W-1:0]   i_q, i_d, k_q, k_d, piv_q, piv_d, piv_n, k_first, k_next;
  logic [mpi_pkg::JW-1:0]      j_q, j_d;
  logic [mpi_pkg::CNT_W-1:0]   n_q, n_d, ld_q, ld_d, total;
  logic [mpi_pkg::JW-1:0]      width2;
  logic                        next_col;

  function automatic logic [mpi_pkg::IN_AW-1:0] in_addr(input logic [3:0] r,
                                                        input logic [3:0] c,
                                                        input logic [3:0] n);
    logic [7:0] t;
    t = {4'b0, r} * {4'b0, n} + {4'b0, c};
    return t[mpi_pkg::IN_AW-1:0];
  endfunction

  function automatic logic [mpi_pkg::AUG_AW-1:0] aug_addr(input logic [3:0] r,
                                                          input logic [4:0] c);
    logic [8:0] t;
    t = {5'b0, r} * 9'(mpi_pkg::AUG_W) + {4'b0, c};
    return t[mpi_pkg::AUG_AW-1:0];
  endfunction

  assign total   = mpi_pkg::CNT_W'({4'b0, nr_i} * {4'b0, nc_i});
  assign width2  = {nc_i, 1'b0};
  assign k_first = (i_q == '0) ? 4'd1 : 4'd0;
  assign piv_n   = ((k_q == i_q) || status_i.mag_gt) ? k_q : piv_q;

  // Next row to eliminate, stepping over the pivot row.
  always_comb begin
    k_next = k_q + 4'd1;
    if (k_next == i_q) k_next = i_q + 4'd1;
  end

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    piv_d    = piv_q;
    n_d      = n_q;
    ld_d     = ld_q;
    next_col = 1'b0;
    cmd_o    = '0;

    case (state_q)
      S_G_RD, S_G_MUL: begin
        cmd_o.in_raddr_a = in_addr(k_q, i_q, nc_i);
        cmd_o.in_raddr_b = in_addr(k_q, j_q[3:0], nc_i);
      end
      S_O_RD, S_O_MUL: begin
        cmd_o.aug_raddr_a = aug_addr(i_q, {1'b0, nc_i} + {1'b0, k_q});
        cmd_o.in_raddr_a  = in_addr(j_q[3:0], k_q, nc_i);
      end
      S_P_RD, S_P_CMP: cmd_o.aug_raddr_a = aug_addr(k_q, {1'b0, i_q});
      S_SW_RD, S_SW_W1, S_SW_W2: begin
        cmd_o.aug_raddr_a = aug_addr(i_q, j_q);
        cmd_o.aug_raddr_b = aug_addr(piv_q, j_q);
      end
      S_D_RD, S_D_CHK: cmd_o.aug_raddr_a = aug_addr(i_q, {1'b0, i_q});
      S_N_RD, S_N_GO:  cmd_o.aug_raddr_a = aug_addr(i_q, j_q);
      S_F_RD, S_F_LD:  cmd_o.aug_raddr_a = aug_addr(k_q, {1'b0, i_q});
      S_E_RD, S_E_MUL, S_E_WR: begin
        cmd_o.aug_raddr_a = aug_addr(k_q, j_q);
        cmd_o.aug_raddr_b = aug_addr(i_q, j_q);
      end
      default: ;
    endcase
    cmd_o.res_addr = n_q[mpi_pkg::RES_AW-1:0];
    cmd_o.in_waddr = ld_q[mpi_pkg::IN_AW-1:0];

    case (state_q)
      S_IDLE: begin
        cmd_o.in_we = in_valid_i;
        if (cfg_wr_i) begin
          ld_d = '0;
        end else if (in_valid_i) begin
          if (ld_q + 7'd1 == total) begin
            ld_d          = '0;
            cmd_o.sat_clr = 1'b1;
            i_d           = '0;
            j_d           = '0;
            k_d           = '0;
            state_d       = S_G_RD;
          end else begin
            ld_d = ld_q + 7'd1;
          end
        end
      end
      S_G_RD: begin
        cmd_o.acc_clr = (k_q == '0);
        state_d       = S_G_MUL;
      end
      S_G_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mpi_pkg::MUL_GRAM;
        state_d       = S_G_ACC;
      end
      S_G_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (k_q + 4'd1 == nr_i) begin
          state_d = S_G_W1;
        end else begin
          k_d     = k_q + 4'd1;
          state_d = S_G_RD;
        end
      end
      S_G_W1: begin
        cmd_o.aug_we    = 1'b1;
        cmd_o.aug_waddr = aug_addr(i_q, j_q);
        cmd_o.aug_wsel  = mpi_pkg::W_ACC;
        state_d         = S_G_W2;
      end
      S_G_W2: begin
        cmd_o.aug_we    = 1'b1;
        cmd_o.aug_waddr = aug_addr(i_q, {1'b0, nc_i} + j_q);
        cmd_o.aug_wsel  = ({1'b0, i_q} == j_q) ? mpi_pkg::W_ONE : mpi_pkg::W_ZERO;
        k_d             = '0;
        if (j_q + 5'd1 == {1'b0, nc_i}) begin
          j_d = '0;
          if (i_q + 4'd1 == nc_i) begin
            i_d     = '0;
            k_d     = '0;
            state_d = S_P_RD;
          end else begin
            i_d     = i_q + 4'd1;
            state_d = S_G_RD;
          end
        end else begin
          j_d     = j_q + 5'd1;
          state_d = S_G_RD;
        end
      end
      S_P_RD: state_d = S_P_CMP;
      S_P_CMP: begin
        cmd_o.best_ld    = 1'b1;
        cmd_o.best_first = (k_q == i_q);
        piv_d            = piv_n;
        if (k_q + 4'd1 == nc_i) begin
          j_d     = '0;
          state_d = (piv_n != i_q) ? S_SW_RD : S_D_RD;
        end else begin
          k_d     = k_q + 4'd1;
          state_d = S_P_RD;
        end
      end
      S_SW_RD: state_d = S_SW_W1;
      S_SW_W1: begin
        cmd_o.aug_we    = 1'b1;
        cmd_o.aug_waddr = aug_addr(i_q, j_q);
        cmd_o.aug_wsel  = mpi_pkg::W_PORT_B;
        state_d         = S_SW_W2;
      end
      S_SW_W2: begin
        cmd_o.aug_we    = 1'b1;
        cmd_o.aug_waddr = aug_addr(piv_q, j_q);
        cmd_o.aug_wsel  = mpi_pkg::W_PORT_A;
        if (j_q + 5'd1 == width2) begin
          state_d = S_D_RD;
        end else begin
          j_d     = j_q + 5'd1;
          state_d = S_SW_RD;
        end
      end
      S_D_RD: state_d = S_D_CHK;
      S_D_CHK: begin
        cmd_o.d_ld = 1'b1;
        if (status_i.a_zero) begin
          next_col = 1'b1;
        end else begin
          j_d     = '0;
          state_d = S_N_RD;
        end
      end
      S_N_RD: state_d = S_N_GO;
      S_N_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_N_WAIT;
      end
      S_N_WAIT: begin
        if (!status_i.div_busy) state_d = S_N_WR;
      end
      S_N_WR: begin
        cmd_o.aug_we    = 1'b1;
        cmd_o.aug_waddr = aug_addr(i_q, j_q);
        cmd_o.aug_wsel  = mpi_pkg::W_QUOT;
        if (j_q + 5'd1 == width2) begin
          k_d = k_first;
          if (k_first >= nc_i) next_col = 1'b1;
          else state_d = S_F_RD;
        end else begin
          j_d     = j_q + 5'd1;
          state_d = S_N_RD;
        end
      end
      S_F_RD: state_d = S_F_LD;
      S_F_LD: begin
        cmd_o.f_ld = 1'b1;
        j_d        = '0;
        state_d    = S_E_RD;
      end
      S_E_RD: state_d = S_E_MUL;
      S_E_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mpi_pkg::MUL_ELIM;
        state_d       = S_E_WR;
      end
      S_E_WR: begin
        cmd_o.aug_we    = 1'b1;
        cmd_o.aug_waddr = aug_addr(k_q, j_q);
        cmd_o.aug_wsel  = mpi_pkg::W_DIFF;
        if (j_q + 5'd1 == width2) begin
          if (k_next >= nc_i) begin
            next_col = 1'b1;
          end else begin
            k_d     = k_next;
            state_d = S_F_RD;
          end
        end else begin
          j_d     = j_q + 5'd1;
          state_d = S_E_RD;
        end
      end
      S_O_RD: begin
        cmd_o.acc_clr = (k_q == '0);
        state_d       = S_O_MUL;
      end
      S_O_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mpi_pkg::MUL_OUT;
        state_d       = S_O_ACC;
      end
      S_O_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (k_q + 4'd1 == nc_i) begin
          state_d = S_O_WR;
        end else begin
          k_d     = k_q + 4'd1;
          state_d = S_O_RD;
        end
      end
      S_O_WR: begin
        cmd_o.res_we = 1'b1;
        n_d          = n_q + 7'd1;
        k_d          = '0;
        state_d      = S_O_RD;
        if (j_q + 5'd1 == {1'b0, nr_i}) begin
          j_d = '0;
          if (i_q + 4'd1 == nc_i) begin
            i_d     = '0;
            n_d     = '0;
            state_d = S_X_RD;
          end else begin
            i_d = i_q + 4'd1;
          end
        end else begin
          j_d = j_q + 5'd1;
        end
      end
      S_X_RD: state_d = S_X_SHOW;
      S_X_SHOW: begin
        if (out_ready_i) begin
          if (n_q + 7'd1 == total) begin
            n_d     = '0;
            i_d     = '0;
            j_d     = '0;
            state_d = S_IDLE;
          end else begin
            n_d     = n_q + 7'd1;
            state_d = S_X_RD;
            if (j_q + 5'd1 == {1'b0, nr_i}) begin
              j_d = '0;
              i_d = i_q + 4'd1;
            end else begin
              j_d = j_q + 5'd1;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (next_col) begin
      if (i_q + 4'd1 == nc_i) begin
        i_d     = '0;
        j_d     = '0;
        k_d     = '0;
        n_d     = '0;
        state_d = S_O_RD;
      end else begin
        i_d     = i_q + 4'd1;
        k_d     = i_q + 4'd1;
        state_d = S_P_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      piv_q   <= '0;
      n_q     <= '0;
      ld_q    <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      piv_q   <= piv_d;
      n_q     <= n_d;
      ld_q    <= ld_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_X_SHOW);
  assign out_row_o   = i_q[2:0];
  assign out_col_o   = j_q[2:0];
  assign out_last_o  = (n_q + 7'd1 == total);

endmodule

`default_nettype wire

@@ test/matrix_pseudo_inverse_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_pseudo_inverse_core_test
// Streams fixed-point matrices of many sizes into the pseudo-inverse core,
// predicts every result word with a behavioral Gauss-Jordan model and checks
// the words in order, under random idling and back-pressure on both channels.
// ----------------------------------------------------------------------------

module matrix_pseudo_inverse_core_test;

  localparam int HOLD_CYCLES = 2000;
  localparam int STALL_LIMIT = 100000;
  localparam int SETTLE      = 50;
  localparam int ONE_Q       = 65536;
  localparam int unsigned AW = mpi_pkg::CFG_AW;

  typedef struct {
    int       value;
    bit [2:0] row;
    bit [2:0] col;
    bit       last;
    bit       sat;
  } pinv_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mpi_elem_if   elem_ch ();
  mpi_result_if res_ch ();

  matrix_pseudo_inverse_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .elem_in (elem_ch),
    .res_out (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    elem_ch.valid = 1'b0;
    elem_ch.element_value = '0;
    res_ch.ready = 1'b0;
  end

  // Words waiting to be offered on the element channel, and the predicted
  // result words in the order the core must send them.
  int         pending_elems[$];
  pinv_word_t expected_words[$];

  // Idle percentages of the sender and receiver; changed between phases.
  int send_idle_pct = 20;
  int recv_idle_pct = 87;
  int failures = 0;
  bit elem_took = 1'b0;

  // A hold-off is requested by bumping hold_requests; the receiver serves it.
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  // ---------------------------------------------------------------------------
  // Behavioral model of the core: count registers, the loaded elements and the
  // elimination array, all at the same Q16.16 precision as the hardware.
  // ---------------------------------------------------------------------------
  logic [3:0] row_reg = mpi_pkg::COUNT_RESET;
  logic [3:0] col_reg = mpi_pkg::COUNT_RESET;
  int         loaded[mpi_pkg::IN_DEPTH];
  int         aug[mpi_pkg::MAX_COLS][mpi_pkg::AUG_W];
  int         load_cnt = 0;
  bit         sat_seen = 1'b0;

  function automatic int clamp_count(logic [3:0] v);
    if (v == 0) return 1;
    if (v > 8) return 8;
    return int'(v);
  endfunction

  function automatic int saturate(longint v);
    if (v > 64'sd2147483647) begin
      sat_seen = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat_seen = 1'b1;
      return 32'h80000000;
    end
    return int'(v);
  endfunction

  // Truncating product: the arithmetic shift rounds toward minus infinity.
  function automatic int q_mul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return saturate(p >>> 16);
  endfunction

  function automatic longint magnitude(int v);
    longint w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  function automatic void solve_pinv(int nr, int nc);
    int acc, piv, d, f, t;
    longint best, m, num;
    pinv_word_t w;
    pinv_word_t run[$];
    sat_seen = 1'b0;
    // Gram matrix on the left half, identity on the right half.
    for (int i = 0; i < nc; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = 0;
        for (int k = 0; k < nr; k++)
          acc = saturate(longint'(acc) + q_mul(loaded[k*nc+i], loaded[k*nc+j]));
        aug[i][j] = acc;
        aug[i][nc+j] = (i == j) ? ONE_Q : 0;
      end
    end
    // Gauss-Jordan with partial pivoting; the first largest magnitude wins and
    // a column whose pivot is exactly zero is skipped.
    for (int i = 0; i < nc; i++) begin
      piv = i;
      best = magnitude(aug[i][i]);
      for (int k = i + 1; k < nc; k++) begin
        m = magnitude(aug[k][i]);
        if (m > best) begin
          best = m;
          piv = k;
        end
      end
      if (piv != i) begin
        for (int j = 0; j < 2*nc; j++) begin
          t = aug[i][j];
          aug[i][j] = aug[piv][j];
          aug[piv][j] = t;
        end
      end
      d = aug[i][i];
      if (d == 0) continue;
      for (int j = 0; j < 2*nc; j++) begin
        num = longint'(aug[i][j]) * 64'sd65536;
        aug[i][j] = saturate(num / longint'(d));
      end
      for (int k = 0; k < nc; k++) begin
        if (k == i) continue;
        f = aug[k][i];
        for (int j = 0; j < 2*nc; j++)
          aug[k][j] = saturate(longint'(aug[k][j]) - q_mul(f, aug[i][j]));
      end
    end
    // Inverse times the transpose; the flag covers the whole run.
    for (int i = 0; i < nc; i++) begin
      for (int j = 0; j < nr; j++) begin
        acc = 0;
        for (int k = 0; k < nc; k++)
          acc = saturate(longint'(acc) + q_mul(aug[i][nc+k], loaded[j*nc+k]));
        w.value = acc;
        w.row = 3'(i);
        w.col = 3'(j);
        w.last = 1'b0;
        w.sat = 1'b0;
        run.push_back(w);
      end
    end
    run[run.size()-1].last = 1'b1;
    foreach (run[n]) begin
      run[n].sat = sat_seen;
      expected_words.push_back(run[n]);
    end
  endfunction

  function automatic void load_element(int v);
    int nr, nc;
    nr = clamp_count(row_reg);
    nc = clamp_count(col_reg);
    if (load_cnt >= nr*nc) load_cnt = 0;
    loaded[load_cnt] = v;
    load_cnt++;
    if (load_cnt < nr*nc) return;
    load_cnt = 0;
    solve_pinv(nr, nc);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: a new word may go out at the falling edge once the previous one was
  // taken. valid gets at most one nonblocking assignment per edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!elem_ch.valid || elem_took)) begin
      if (pending_elems.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        elem_ch.valid <= 1'b1;
        elem_ch.element_value <= pending_elems.pop_front();
      end else begin
        elem_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random idling, plus a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_ch.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: feeds accepted elements to the model, checks every result word
  // against the oldest prediction and runs the stall watchdog.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    pinv_word_t exp_w;
    elem_took = elem_ch.valid && elem_ch.ready;
    if (elem_took) load_element(elem_ch.element_value);
    if (res_ch.valid && res_ch.ready) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: value %0d row %0d col %0d",
               res_ch.result_value, res_ch.result_row, res_ch.result_col);
        failures++;
      end else begin
        exp_w = expected_words.pop_front();
        if (res_ch.result_value !== exp_w.value) begin
          $error("result_value expected %0d actual %0d", exp_w.value, res_ch.result_value);
          failures++;
        end
        if (res_ch.result_row !== exp_w.row) begin
          $error("result_row expected %0d actual %0d", exp_w.row, res_ch.result_row);
          failures++;
        end
        if (res_ch.result_col !== exp_w.col) begin
          $error("result_col expected %0d actual %0d", exp_w.col, res_ch.result_col);
          failures++;
        end
        if (res_ch.last_of_run !== exp_w.last) begin
          $error("last_of_run expected %0d actual %0d", exp_w.last, res_ch.last_of_run);
          failures++;
        end
        if (res_ch.saturated !== exp_w.sat) begin
          $error("saturated expected %0d actual %0d", exp_w.sat, res_ch.saturated);
          failures++;
        end
      end
    end
    // Anything accepted on any port counts as progress.
    if (elem_took || (res_ch.valid && res_ch.ready) || (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // APB write: setup cycle, then access cycle; the register is taken at the
  // rising edge of the access cycle, and the model follows right after it.
  task automatic write_count(logic sel, logic [3:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= (sel == mpi_pkg::REG_COL_COUNT) ? AW'(4) : AW'(0);
    pwdata <= {28'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    #1;
    if (sel == mpi_pkg::REG_COL_COUNT) col_reg = val;
    else row_reg = val;
    load_cnt = 0;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Waits until every pending word was taken and every prediction has come
  // back, then lets the core settle before registers change.
  task automatic wait_drained();
    while (pending_elems.size() > 0 || elem_ch.valid || expected_words.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic int random_element();
    int pick;
    pick = $urandom_range(99);
    if (pick < 12) return int'($urandom());
    if (pick < 20) return 0;
    if (pick < 26) return ONE_Q;
    return int'($urandom_range(32'h3ffff)) - 32'h20000;
  endfunction

  task automatic push_matrices(int nmat);
    int total;
    total = clamp_count(row_reg) * clamp_count(col_reg);
    repeat (nmat * total) pending_elems.push_back(random_element());
  endtask

  task automatic set_idling(int sent);
    if (sent < 55) begin
      send_idle_pct = 20;
      recv_idle_pct = 87;
    end else if (sent < 105) begin
      send_idle_pct = 87;
      recv_idle_pct = 20;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  int sent_random;
  int nmat;
  bit big_done;
  logic [3:0] rows_v;
  logic [3:0] cols_v;

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // 1 x 1 matrices: extreme values, the unit value, a tiny value, and zero,
    // which gives a zero pivot.
    write_count(mpi_pkg::REG_ROW_COUNT, 4'd1);
    write_count(mpi_pkg::REG_COL_COUNT, 4'd1);
    pending_elems.push_back(32'h7fffffff);
    pending_elems.push_back(32'h80000000);
    pending_elems.push_back(0);
    pending_elems.push_back(ONE_Q);
    pending_elems.push_back(1);
    wait_drained();

    // A zero count behaves as one.
    write_count(mpi_pkg::REG_ROW_COUNT, 4'd0);
    pending_elems.push_back(32'h00030000);
    wait_drained();

    // All-equal 2 x 2: pivot ties everywhere and a singular Gram matrix.
    write_count(mpi_pkg::REG_ROW_COUNT, 4'd2);
    write_count(mpi_pkg::REG_COL_COUNT, 4'd2);
    repeat (4) pending_elems.push_back(ONE_Q);
    wait_drained();

    // A count above the maximum behaves as the maximum: an 8 x 1 column.
    write_count(mpi_pkg::REG_ROW_COUNT, 4'd15);
    write_count(mpi_pkg::REG_COL_COUNT, 4'd1);
    for (int n = 0; n < 8; n++) pending_elems.push_back(int'($urandom()));
    wait_drained();

    // A count write in the middle of a load restarts the load.
    write_count(mpi_pkg::REG_ROW_COUNT, 4'd2);
    write_count(mpi_pkg::REG_COL_COUNT, 4'd2);
    repeat (3) pending_elems.push_back(random_element());
    wait_drained();
    write_count(mpi_pkg::REG_ROW_COUNT, 4'd1);
    pending_elems.push_back(32'h00020000);
    pending_elems.push_back(32'hffff0000);
    wait_drained();

    // Random part: mostly small shapes, one full 8 x 8 run, odd count codes.
    sent_random = 0;
    big_done = 1'b0;
    while (sent_random < 145) begin
      set_idling(sent_random);
      if (!big_done && sent_random > 75) begin
        rows_v = 4'd8;
        cols_v = 4'd8;
        big_done = 1'b1;
      end else begin
        rows_v = 4'($urandom_range(1, 4));
        cols_v = 4'($urandom_range(1, 4));
        if ($urandom_range(9) == 0) rows_v = 4'($urandom_range(9, 15));
        if ($urandom_range(9) == 0) cols_v = 4'($urandom_range(0, 1));
        if ($urandom_range(9) == 0) rows_v = 4'd0;
      end
      if ($urandom_range(1) == 1) begin
        write_count(mpi_pkg::REG_ROW_COUNT, rows_v);
        write_count(mpi_pkg::REG_COL_COUNT, cols_v);
      end else begin
        write_count(mpi_pkg::REG_COL_COUNT, cols_v);
        write_count(mpi_pkg::REG_ROW_COUNT, rows_v);
      end
      nmat = big_done && rows_v == 8 && cols_v == 8 ? 1 : $urandom_range(1, 3);
      // On the first set the receiver holds off for a long stretch while the
      // sender keeps offering, so the core fills up and stalls its input.
      if (sent_random == 0) begin
        nmat = 3;
        hold_requests++;
      end
      push_matrices(nmat);
      sent_random += nmat * clamp_count(rows_v) * clamp_count(cols_v);
      // Now and then push one to three extra elements; a partial load that they
      // leave behind is discarded by the next count write.
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(1, 3)) pending_elems.push_back(random_element());
        sent_random += 1;
      end
      wait_drained();
    end

    wait_drained();
    if (failures == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ matrix_pseudo_inverse_core.f @@
design/mpi_pkg.sv
design/mpi_if.sv
design/mpi_ram.sv
design/mpi_divider.sv
design/mpi_datapath.sv
design/mpi_controller.sv
design/matrix_pseudo_inverse_core.sv
test/matrix_pseudo_inverse_core_test.sv
